>>> rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

    // calibration register file
    localparam int NUM_CAL   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CAL_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CAL_AC1_AC2 = 3'd0,
        CAL_AC3_AC4 = 3'd1,
        CAL_AC5_AC6 = 3'd2,
        CAL_B1_B2   = 3'd3,
        CAL_MC_MD   = 3'd4
    } cal_idx_t;

    // unpacked coefficients
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } cal_t;

    // divider widths: temperature quotient/divisor, pressure quotient/divisor
    localparam int TQ_W = 27;
    localparam int TD_W = 19;
    localparam int PQ_W = 32;
    localparam int PD_W = 17;

    // sideband carried through the temperature divider
    typedef struct packed {
        logic signed [18:0] x1;
        logic               neg;
        logic               fault;
        logic        [15:0] up;
    } tside_t;

    // sideband carried through the pressure divider
    typedef struct packed {
        logic signed [15:0] t;
        logic               fault;
        logic               dbl;
    } pside_t;

    // compensation constants
    localparam logic signed [29:0] T_OFFSET = 30'sd4000;
    localparam logic        [31:0] P_HALF   = 32'd32768;
    localparam logic        [31:0] P_SCALE  = 32'd50000;
    localparam logic        [11:0] P_C1     = 12'd3038;
    localparam logic signed [47:0] P_C2     = -48'sd7357;
    localparam logic signed [48:0] P_C3     = 49'sd3791;

    // stage counts
    localparam int FRONT_LAT = 3;
    localparam int COEF_LAT  = 8;
    localparam int PRESS_LAT = 4;
    localparam int PIPE_LAT  = FRONT_LAT + TQ_W + COEF_LAT + PQ_W + PRESS_LAT;

endpackage

>>> rtl/core/bpc_div.sv
`timescale 1ns / 1ps

module bpc_div
#(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          v_reg    [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          cur_v;
        logic [NW-1:0] cur_nq;
        logic [DW-1:0] cur_rem;
        logic [DW-1:0] cur_den;
        logic [SW-1:0] cur_side;
        logic [DW:0]   trial;
        logic [DW:0]   trial_sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_nq   = in_num;
            assign cur_rem  = '0;
            assign cur_den  = in_den;
            assign cur_side = in_side;
        end
        else begin : g_next
            assign cur_v    = v_reg[k-1];
            assign cur_nq   = nq_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_den  = den_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign trial     = {cur_rem, cur_nq[NW-1]};
        assign trial_sub = trial - {1'b0, cur_den};
        assign ge        = (trial >= {1'b0, cur_den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            nq_reg[k]   <= {cur_nq[NW-2:0], ge};
            rem_reg[k]  <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            den_reg[k]  <= cur_den;
            side_reg[k] <= cur_side;
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

>>> rtl/core/bpc_coef.sv
`timescale 1ns / 1ps

module bpc_coef
    import bpc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cal_t            cal,
    input  logic            in_valid,
    input  logic [TQ_W-1:0] in_quo,
    input  tside_t          in_side,
    output logic            out_valid,
    output logic [PQ_W-1:0] out_num,
    output logic [PD_W-1:0] out_den,
    output pside_t          out_side
);

    logic [COEF_LAT-1:0] v_reg;

    logic signed [27:0] x2;
    logic signed [28:0] c1_b5_reg, c1_b5_next;
    logic signed [15:0] c2_t_reg, c2_t_next;
    logic signed [29:0] c2_b6_reg, c2_b6_next;
    logic signed [59:0] c3_sqf_reg, c3_sqf_next;
    logic signed [45:0] c3_ac2b6_reg, c3_ac2b6_next;
    logic signed [45:0] c3_ac3b6_reg, c3_ac3b6_next;
    logic        [45:0] sq;
    logic signed [62:0] c4_b2sq_reg, c4_b2sq_next;
    logic signed [62:0] c4_b1sq_reg, c4_b1sq_next;
    logic signed [45:0] c4_ac2b6_reg;
    logic signed [45:0] c4_ac3b6_reg;
    logic        [33:0] c5_xa_reg, c5_xa_next;
    logic        [33:0] c5_xb_reg, c5_xb_next;
    logic        [33:0] b3_sum;
    logic        [33:0] x3_sum;
    logic        [31:0] c6_b3_reg;
    logic        [31:0] c6_x3_reg;
    logic        [31:0] c7_dif_reg, c7_dif_next;
    logic        [31:0] c7_u_reg, c7_u_next;
    logic        [31:0] b4_prod;
    logic        [PD_W-1:0] c8_b4_reg;
    logic        [31:0] c8_b7_reg, c8_b7_next;

    logic        [15:0] up_reg [COEF_LAT-2];
    logic        [15:0] t_reg  [COEF_LAT-2];
    logic               fault_reg [COEF_LAT];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[COEF_LAT-2:0], in_valid};
    end

    // stage 1: signed quotient and b5
    assign x2         = in_side.neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
    assign c1_b5_next = 29'(in_side.x1) + 29'(x2);

    // stage 2: temperature and b6
    assign c2_t_next  = 16'((c1_b5_reg + 29'sd8) >>> 4);
    assign c2_b6_next = 30'(c1_b5_reg) - T_OFFSET;

    // stage 3: square of b6 and the b6 products
    assign c3_sqf_next   = c2_b6_reg * c2_b6_reg;
    assign c3_ac2b6_next = cal.ac2 * c2_b6_reg;
    assign c3_ac3b6_next = cal.ac3 * c2_b6_reg;

    // stage 4: products with the shifted square
    assign sq           = c3_sqf_reg[57:12];
    assign c4_b2sq_next = cal.b2 * $signed({1'b0, sq});
    assign c4_b1sq_next = cal.b1 * $signed({1'b0, sq});

    // stage 5: x3 sums, low bits only
    assign c5_xa_next = 34'(c4_b2sq_reg >>> 11) + 34'(c4_ac2b6_reg >>> 11);
    assign c5_xb_next = 34'(c4_ac3b6_reg >>> 13) + 34'(c4_b1sq_reg >>> 16);

    // stage 6: b3 and rounded x3
    assign b3_sum = 34'($signed({cal.ac1, 2'b00})) + c5_xa_reg + 34'd2;
    assign x3_sum = c5_xb_reg + 34'd2;

    // stage 7: up - b3 and x3 + 32768
    assign c7_dif_next = {16'd0, up_reg[COEF_LAT-3]} - c6_b3_reg;
    assign c7_u_next   = c6_x3_reg + P_HALF;

    // stage 8: b4 and b7
    assign b4_prod    = cal.ac4 * c7_u_reg;
    assign c8_b7_next = c7_dif_reg * P_SCALE;

    always_ff @(posedge clk)
    begin
        c1_b5_reg    <= c1_b5_next;
        c2_t_reg     <= c2_t_next;
        c2_b6_reg    <= c2_b6_next;
        c3_sqf_reg   <= c3_sqf_next;
        c3_ac2b6_reg <= c3_ac2b6_next;
        c3_ac3b6_reg <= c3_ac3b6_next;
        c4_b2sq_reg  <= c4_b2sq_next;
        c4_b1sq_reg  <= c4_b1sq_next;
        c4_ac2b6_reg <= c3_ac2b6_reg;
        c4_ac3b6_reg <= c3_ac3b6_reg;
        c5_xa_reg    <= c5_xa_next;
        c5_xb_reg    <= c5_xb_next;
        c6_b3_reg    <= b3_sum[33:2];
        c6_x3_reg    <= x3_sum[33:2];
        c7_dif_reg   <= c7_dif_next;
        c7_u_reg     <= c7_u_next;
        c8_b4_reg    <= b4_prod[31:15];
        c8_b7_reg    <= c8_b7_next;
    end

    // sideband delay lines
    always_ff @(posedge clk)
    begin
        up_reg[0]    <= in_side.up;
        fault_reg[0] <= in_side.fault;
        t_reg[0]     <= c2_t_reg;
        for (int i = 1; i < COEF_LAT - 2; i++)
            up_reg[i] <= up_reg[i-1];
        for (int i = 1; i < COEF_LAT; i++)
            fault_reg[i] <= fault_reg[i-1];
        for (int i = 1; i < COEF_LAT - 2; i++)
            t_reg[i] <= t_reg[i-1];
    end

    // numerator select for the pressure divide
    assign out_valid      = v_reg[COEF_LAT-1];
    assign out_den        = c8_b4_reg;
    assign out_num        = c8_b7_reg[31] ? c8_b7_reg : {c8_b7_reg[30:0], 1'b0};
    assign out_side.dbl   = c8_b7_reg[31];
    assign out_side.fault = fault_reg[COEF_LAT-1] || (c8_b4_reg == '0);
    assign out_side.t     = t_reg[COEF_LAT-3];

endmodule

>>> rtl/core/bpc_press.sv
`timescale 1ns / 1ps

module bpc_press
    import bpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PQ_W-1:0]    in_quo,
    input  pside_t             in_side,
    output logic               done,
    output logic signed [15:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic               divide_fault
);

    logic [PRESS_LAT-2:0] v_reg;
    logic                 done_reg;

    logic        [32:0] p_next;
    logic        [32:0] p_reg [PRESS_LAT-1];
    pside_t             side_reg [PRESS_LAT-1];
    logic        [49:0] p1_sqp_reg, p1_sqp_next;
    logic signed [47:0] p1_m2_reg, p1_m2_next;
    logic        [61:0] p2_a_reg, p2_a_next;
    logic signed [31:0] p2_m2s_reg;
    logic signed [48:0] p3_sum_reg, p3_sum_next;
    logic        [31:0] pres;

    logic signed [15:0] t_out_reg;
    logic signed [31:0] p_out_reg;
    logic               fault_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[PRESS_LAT-3:0], in_valid};
            done_reg <= v_reg[PRESS_LAT-2];
        end
    end

    // stage 1: restore p, square of p>>8, linear term
    assign p_next      = in_side.dbl ? {in_quo, 1'b0} : {1'b0, in_quo};
    assign p1_sqp_next = p_next[32:8] * p_next[32:8];
    assign p1_m2_next  = $signed({15'd0, p_next}) * P_C2;

    // stage 2: quadratic coefficient
    assign p2_a_next = p1_sqp_reg * P_C1;

    // stage 3: correction sum
    assign p3_sum_next = $signed({3'b000, p2_a_reg[61:16]}) + 49'(p2_m2s_reg) + P_C3;

    // stage 4: final pressure
    assign pres = p_reg[PRESS_LAT-2][31:0] + 32'(p3_sum_reg >>> 4);

    always_ff @(posedge clk)
    begin
        p_reg[0]    <= p_next;
        side_reg[0] <= in_side;
        for (int i = 1; i < PRESS_LAT - 1; i++)
        begin
            p_reg[i]    <= p_reg[i-1];
            side_reg[i] <= side_reg[i-1];
        end
        p1_sqp_reg <= p1_sqp_next;
        p1_m2_reg  <= p1_m2_next;
        p2_a_reg   <= p2_a_next;
        p2_m2s_reg <= 32'(p1_m2_reg >>> 16);
        p3_sum_reg <= p3_sum_next;
    end

    // output register, zeros on a divide fault
    always_ff @(posedge clk)
    begin
        fault_out_reg <= side_reg[PRESS_LAT-2].fault;
        t_out_reg     <= side_reg[PRESS_LAT-2].fault ? 16'sd0 : side_reg[PRESS_LAT-2].t;
        p_out_reg     <= side_reg[PRESS_LAT-2].fault ? 32'sd0 : $signed(pres);
    end

    assign done               = done_reg;
    assign temperature_tenths = t_out_reg;
    assign pressure_pa        = p_out_reg;
    assign divide_fault       = fault_out_reg;

endmodule

>>> rtl/core/barometric_pressure_compensation.sv
`timescale 1ns / 1ps

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+----------------------------
// input     | raw_temperature, raw_pressure                 | taken when start && !busy
// result    | temperature_tenths, pressure_pa, divide_fault | done high for one cycle
// config    | cfg_index, cfg_data                           | written when cfg_we
//
// one item enters every cycle
// the two dividers give one quotient bit per stage (27 and 32 stages)
// busy stays low: the pipeline never holds an item back
// reset clears the calibration registers and all valid bits

module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          raw_temperature,
    input  logic [15:0]          raw_pressure,
    output logic                 done,
    output logic signed [15:0]   temperature_tenths,
    output logic signed [31:0]   pressure_pa,
    output logic                 divide_fault,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    logic [CAL_W-1:0] cal_reg [NUM_CAL];
    cal_t             cal;

    logic               accept;
    logic [FRONT_LAT-1:0] v_reg;
    logic signed [16:0] f1_d_reg, f1_d_next;
    logic signed [33:0] f2_prod_reg, f2_prod_next;
    logic signed [18:0] f3_x1_reg, f3_x1_next;
    logic signed [18:0] f3_den_reg, f3_den_next;
    logic [15:0]        up_reg [FRONT_LAT];

    logic [TD_W-1:0]    den_mag;
    logic [15:0]        mc_mag;
    tside_t             tdiv_side;

    logic               tq_valid;
    logic [TQ_W-1:0]    tq_quo;
    logic [$bits(tside_t)-1:0] tq_side_bits;

    logic               pd_valid;
    logic [PQ_W-1:0]    pd_num;
    logic [PD_W-1:0]    pd_den;
    pside_t             pd_side;

    logic               pq_valid;
    logic [PQ_W-1:0]    pq_quo;
    logic [$bits(pside_t)-1:0] pq_side_bits;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAL; i++)
                cal_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index <= CAL_MC_MD))
        begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    assign cal.ac1 = cal_reg[CAL_AC1_AC2][31:16];
    assign cal.ac2 = cal_reg[CAL_AC1_AC2][15:0];
    assign cal.ac3 = cal_reg[CAL_AC3_AC4][31:16];
    assign cal.ac4 = cal_reg[CAL_AC3_AC4][15:0];
    assign cal.ac5 = cal_reg[CAL_AC5_AC6][31:16];
    assign cal.ac6 = cal_reg[CAL_AC5_AC6][15:0];
    assign cal.b1  = cal_reg[CAL_B1_B2][31:16];
    assign cal.b2  = cal_reg[CAL_B1_B2][15:0];
    assign cal.mc  = cal_reg[CAL_MC_MD][31:16];
    assign cal.md  = cal_reg[CAL_MC_MD][15:0];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[FRONT_LAT-2:0], accept};
    end

    // front: ut - ac6, times ac5, shift and add md
    assign f1_d_next    = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ac6});
    assign f2_prod_next = f1_d_reg * $signed({1'b0, cal.ac5});
    assign f3_x1_next   = 19'(f2_prod_reg >>> 15);
    assign f3_den_next  = f3_x1_next + 19'(cal.md);

    always_ff @(posedge clk)
    begin
        f1_d_reg    <= f1_d_next;
        f2_prod_reg <= f2_prod_next;
        f3_x1_reg   <= f3_x1_next;
        f3_den_reg  <= f3_den_next;
        up_reg[0]   <= raw_pressure;
        for (int i = 1; i < FRONT_LAT; i++)
            up_reg[i] <= up_reg[i-1];
    end

    // magnitudes and signs for the temperature divide
    assign den_mag         = f3_den_reg[18] ? 19'(-f3_den_reg) : f3_den_reg;
    assign mc_mag          = cal.mc[15] ? 16'(-cal.mc) : cal.mc;
    assign tdiv_side.x1    = f3_x1_reg;
    assign tdiv_side.neg   = cal.mc[15] ^ f3_den_reg[18];
    assign tdiv_side.fault = (f3_den_reg == '0);
    assign tdiv_side.up    = up_reg[FRONT_LAT-1];

    bpc_div #(
        .NW (TQ_W),
        .DW (TD_W),
        .SW ($bits(tside_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[FRONT_LAT-1]),
        .in_num    ({mc_mag, 11'd0}),
        .in_den    (den_mag),
        .in_side   (tdiv_side),
        .out_valid (tq_valid),
        .out_quo   (tq_quo),
        .out_side  (tq_side_bits)
    );

    bpc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (tq_valid),
        .in_quo    (tq_quo),
        .in_side   (tside_t'(tq_side_bits)),
        .out_valid (pd_valid),
        .out_num   (pd_num),
        .out_den   (pd_den),
        .out_side  (pd_side)
    );

    bpc_div #(
        .NW (PQ_W),
        .DW (PD_W),
        .SW ($bits(pside_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pd_valid),
        .in_num    (pd_num),
        .in_den    (pd_den),
        .in_side   (pd_side),
        .out_valid (pq_valid),
        .out_quo   (pq_quo),
        .out_side  (pq_side_bits)
    );

    bpc_press u_press (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (pq_valid),
        .in_quo             (pq_quo),
        .in_side            (pside_t'(pq_side_bits)),
        .done               (done),
        .temperature_tenths (temperature_tenths),
        .pressure_pa        (pressure_pa),
        .divide_fault       (divide_fault)
    );

endmodule

>>> rtl/core/bpc_checker.sv
`timescale 1ns / 1ps

module bpc_checker
    import bpc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] temperature_tenths,
    input logic signed [31:0] pressure_pa,
    input logic               divide_fault
);

    // every accepted item gives a result after the fixed latency
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted item produced no result");

    // no result without an accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without an accepted item");

    // a divide fault forces both values to zero
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_fault) |-> (temperature_tenths == 16'sd0 && pressure_pa == 32'sd0))
        else $error("fault result carries nonzero values");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

>>> verif/barometric_pressure_compensation_tb.sv
`timescale 1ns / 1ps

module barometric_pressure_compensation_tb;
    import bpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] temperature;
        logic signed [31:0] pressure;
        logic               fault;
    } reading_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [15:0]          raw_temperature;
    logic [15:0]          raw_pressure;
    logic                 done;
    logic signed [15:0]   temperature_tenths;
    logic signed [31:0]   pressure_pa;
    logic                 divide_fault;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CAL_W-1:0]     cfg_data;

    // mirror of the calibration registers
    logic [31:0] cal_mirror [NUM_CAL];
    reading_t    pending_readings [$];
    int          mismatches;
    int          cycle_count;
    int          idle_pct;

    barometric_pressure_compensation dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .raw_temperature    (raw_temperature),
        .raw_pressure       (raw_pressure),
        .done               (done),
        .temperature_tenths (temperature_tenths),
        .pressure_pa        (pressure_pa),
        .divide_fault       (divide_fault),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // datasheet integer compensation
    function automatic reading_t compensate(logic [15:0] ut, logic [15:0] up);
        longint   ut_l = ut;
        longint   up_l = up;
        longint   ac1 = longint'($signed(cal_mirror[CAL_AC1_AC2][31:16]));
        longint   ac2 = longint'($signed(cal_mirror[CAL_AC1_AC2][15:0]));
        longint   ac3 = longint'($signed(cal_mirror[CAL_AC3_AC4][31:16]));
        longint   ac4 = cal_mirror[CAL_AC3_AC4][15:0];
        longint   ac5 = cal_mirror[CAL_AC5_AC6][31:16];
        longint   ac6 = cal_mirror[CAL_AC5_AC6][15:0];
        longint   b1 = longint'($signed(cal_mirror[CAL_B1_B2][31:16]));
        longint   b2 = longint'($signed(cal_mirror[CAL_B1_B2][15:0]));
        longint   mc = longint'($signed(cal_mirror[CAL_MC_MD][31:16]));
        longint   md = longint'($signed(cal_mirror[CAL_MC_MD][15:0]));
        longint   x1, x2, x3, b3, b5, b6, sq, p, t, pres, den;
        logic [31:0] b4, b7, half_term, ac4_32, prod, quot;
        reading_t r;
        r.temperature = '0;
        r.pressure    = '0;
        r.fault       = 1'b1;

        // temperature
        x1  = ((ut_l - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0)
            return r;
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t  = (b5 + 8) >>> 4;

        // pressure offset and scale
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (ac1 * 4 + x3 + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        half_term = 32'(x3 + 32768);
        ac4_32    = 32'(ac4);
        prod      = ac4_32 * half_term;
        b4        = prod >> 15;
        if (b4 == 0)
            return r;
        b7 = 32'(up_l - b3);
        b7 = b7 * 32'd50000;
        if (b7 < 32'h8000_0000)
        begin
            quot = (b7 << 1) / b4;
            p    = quot;
        end
        else
        begin
            quot = b7 / b4;
            p    = quot;
            p    = p * 2;
        end

        // final correction
        x1   = (p >>> 8) * (p >>> 8);
        x1   = (x1 * 3038) >>> 16;
        x2   = (-7357 * p) >>> 16;
        pres = p + ((x1 + x2 + 3791) >>> 4);

        r.temperature = t[15:0];
        r.pressure    = pres[31:0];
        r.fault       = 1'b0;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result temp=%0d press=%0d fault=%0b", $time,
                         temperature_tenths, pressure_pa, divide_fault);
            end
            else
            begin
                reading_t e;
                e = pending_readings.pop_front();
                if (temperature_tenths !== e.temperature)
                begin
                    mismatches++;
                    $display("%0t: temperature_tenths expected %0d actual %0d", $time,
                             e.temperature, temperature_tenths);
                end
                if (pressure_pa !== e.pressure)
                begin
                    mismatches++;
                    $display("%0t: pressure_pa expected %0d actual %0d", $time,
                             e.pressure, pressure_pa);
                end
                if (divide_fault !== e.fault)
                begin
                    mismatches++;
                    $display("%0t: divide_fault expected %0b actual %0b", $time,
                             e.fault, divide_fault);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // send one item; called and returns at a falling edge
    task automatic send_reading(logic [15:0] ut, logic [15:0] up);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start           <= 1'b1;
        raw_temperature <= ut;
        raw_pressure    <= up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_readings.push_back(compensate(ut, up));
        @(negedge clk);
    endtask

    // wait until every result is back and the pipe is empty
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 8) @(negedge clk);
    endtask

    // register write while idle
    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_CAL)
            cal_mirror[idx] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cal(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                            logic [31:0] r3, logic [31:0] r4);
        drain_pipe();
        write_cal(CAL_AC1_AC2, r0);
        write_cal(CAL_AC3_AC4, r1);
        write_cal(CAL_AC5_AC6, r2);
        write_cal(CAL_B1_B2, r3);
        write_cal(CAL_MC_MD, r4);
    endtask

    task automatic load_datasheet_cal();
        load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
    endtask

    // zero calibration after reset: temperature divisor is zero
    task automatic test_reset_cal();
        send_reading(16'd0, 16'd0);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'd27898, 16'd23843);
    endtask

    // datasheet point plus field extremes
    task automatic test_datasheet();
        load_datasheet_cal();
        send_reading(16'd27898, 16'd23843);
        send_reading(16'd0, 16'd0);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h5555, 16'hAAAA);
        send_reading(16'hAAAA, 16'h5555);
        send_reading(16'd0, 16'hFFFF);
        send_reading(16'hFFFF, 16'd0);
    endtask

    // ac4 of zero gives a zero pressure divisor
    task automatic test_pressure_divisor();
        drain_pipe();
        write_cal(CAL_AC3_AC4, {-16'sd14383, 16'd0});
        send_reading(16'd27898, 16'd23843);
        send_reading(16'd100, 16'd40000);
    endtask

    // out-of-range index is ignored by the block
    task automatic test_bad_index();
        load_datasheet_cal();
        write_cal(3'd5, 32'hFFFF_FFFF);
        write_cal(3'd6, 32'h1234_5678);
        write_cal(3'd7, 32'h0000_0000);
        send_reading(16'd27898, 16'd23843);
        send_reading(16'd30000, 16'd20000);
    endtask

    // coefficient extremes, results wrap
    task automatic test_cal_extremes();
        load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_reading(16'd0, 16'd0);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h8000, 16'h7FFF);
        load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF, 32'h8000_7FFF);
        send_reading(16'd0, 16'hFFFF);
        send_reading(16'hFFFF, 16'd0);
        send_reading(16'd27898, 16'd23843);
    endtask

    // random calibrations and readings
    task automatic test_random_readings();
        for (int blk = 0; blk < 10; blk++)
        begin
            if (blk % 4 == 3)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_cal({16'(408 + $urandom_range(400) - 200),
                          16'(-72 + $urandom_range(200) - 100)},
                         {16'(-14383 + $urandom_range(4000) - 2000),
                          16'(32741 + $urandom_range(2000) - 1000)},
                         {16'(32757 + $urandom_range(600) - 300),
                          16'(23153 + $urandom_range(4000) - 2000)},
                         {16'(6190 + $urandom_range(1000) - 500),
                          16'(4 + $urandom_range(20) - 10)},
                         {16'(-8711 + $urandom_range(2000) - 1000),
                          16'(2868 + $urandom_range(600) - 300)});
            idle_pct = (blk == 2) ? 0 : 21;
            for (int n = 0; n < 70; n++)
            begin
                if (n == 35 && blk == 5)
                    drain_pipe();
                if ($urandom_range(99) < 75)
                    send_reading(16'(27898 + $urandom_range(8000) - 4000),
                                 16'(23843 + $urandom_range(16000) - 8000));
                else
                    send_reading(16'($urandom), 16'($urandom));
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        mismatches      = 0;
        cycle_count     = 0;
        idle_pct        = 21;
        for (int i = 0; i < NUM_CAL; i++)
            cal_mirror[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_cal();
        test_datasheet();
        test_pressure_divisor();
        test_bad_index();
        test_cal_extremes();
        test_random_readings();

        drain_pipe();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
